// ===== rtl/i2cmbw_pkg.sv =====
// Shared types and constants for the I2C master byte writer.
// No dependencies; the channel interfaces and the top level import it.
package i2cmbw_pkg;

   localparam int          TPU_WIDTH = 16;
   localparam logic [15:0] TPU_RESET = 16'd155;
   localparam logic [2:0]  BIT_MSB   = 3'd7;

   typedef struct packed {
      logic       mode;
      logic [7:0] data_byte;
      logic       start_flag;
      logic       stop_flag;
      logic       sda_in;
   } req_word_type;

   typedef struct packed {
      logic scl_low;
      logic sda_low;
      logic busy_res;
      logic byte_done;
      logic ack_level;
      logic rejected;
   } rsp_word_type;

endpackage

// ===== rtl/i2cmbw_ifs.sv =====
// Valid/ready channel interfaces for the I2C master byte writer.
// Depends on i2cmbw_pkg for the word types.
interface i2cmbw_req_if import i2cmbw_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface i2cmbw_rsp_if import i2cmbw_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface i2cmbw_csr_if import i2cmbw_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [TPU_WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/i2c_master_byte_writer_unit.sv =====
// I2C master byte writer: one result word per request word (tick or command).
// Latency: the result word is presented the cycle after its request is taken.
// Throughput: one request per cycle; the only limit is the result register,
// which is refilled in the cycle it is drained.
// Synchronous active-high reset: bus released, idle, ticks_per_unit = 155.
// Depends on i2cmbw_pkg and the channel interfaces in i2cmbw_ifs.sv.
module i2c_master_byte_writer_unit import i2cmbw_pkg::*; #(
   parameter int TICK_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   i2cmbw_req_if.sink   req_bus,
   i2cmbw_rsp_if.source rsp_bus,
   i2cmbw_csr_if.sink   csr_bus
);

   localparam int CMP_W = (TICK_BITS > TPU_WIDTH) ? TICK_BITS : TPU_WIDTH;

   typedef enum logic [3:0] {
      PH_IDLE, PH_START, PH_BIT_LOW, PH_BIT_HIGH, PH_BIT_TAIL, PH_ACK_SETUP,
      PH_ACK_HIGH1, PH_ACK_HIGH2, PH_ACK_TAIL, PH_STOP_LOW, PH_STOP_HIGH
   } phase_type;

   phase_type            phase_ff, phase_in, target;
   logic [2:0]           bit_index_ff, bit_index_in;
   logic [7:0]           shift_ff, shift_in;
   logic [TICK_BITS-1:0] tick_count_ff, tick_count_in, tick_inc;
   logic [1:0]           units_ff, units_in;
   logic                 want_stop_ff, want_stop_in;
   logic                 ack_hold_ff, ack_hold_in;
   logic                 scl_drive_ff, scl_drive_in;
   logic                 sda_drive_ff, sda_drive_in;
   logic [TPU_WIDTH-1:0] tpu_ff, tpu_eff;
   logic [CMP_W-1:0]     cnt_ext, tpu_ext;
   logic                 rsp_valid_ff;
   rsp_word_type         rsp_ff, rsp_in;
   logic                 req_fire, busy, do_enter, done, rej;

   assign req_bus.ready   = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire        = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_ff;
   assign csr_bus.ready   = 1'b1;

   assign busy     = (phase_ff != PH_IDLE);
   assign tick_inc = tick_count_ff + TICK_BITS'(1);
   assign tpu_eff  = (tpu_ff == '0) ? TPU_WIDTH'(1) : tpu_ff;
   assign cnt_ext  = CMP_W'(tick_inc);
   assign tpu_ext  = CMP_W'(tpu_eff);

   always_comb begin
      phase_in      = phase_ff;
      bit_index_in  = bit_index_ff;
      shift_in      = shift_ff;
      tick_count_in = tick_count_ff;
      units_in      = units_ff;
      want_stop_in  = want_stop_ff;
      ack_hold_in   = ack_hold_ff;
      scl_drive_in  = scl_drive_ff;
      sda_drive_in  = sda_drive_ff;
      target        = PH_IDLE;
      do_enter      = 1'b0;
      done          = 1'b0;
      rej           = 1'b0;

      if (req_fire) begin
         if (req_bus.payload.mode) begin
            if (busy) begin
               rej = 1'b1;
            end else begin
               shift_in     = req_bus.payload.data_byte;
               want_stop_in = req_bus.payload.stop_flag;
               bit_index_in = BIT_MSB;
               target       = req_bus.payload.start_flag ? PH_START : PH_BIT_LOW;
               do_enter     = 1'b1;
            end
         end else if (busy) begin
            tick_count_in = tick_inc;
            if (cnt_ext >= tpu_ext) begin
               tick_count_in = '0;
               units_in      = units_ff - 2'd1;
               if (units_in == 2'd0) begin
                  do_enter = 1'b1;
                  case (phase_ff)
                     PH_START:     target = PH_BIT_LOW;
                     PH_BIT_LOW:   target = PH_BIT_HIGH;
                     PH_BIT_HIGH:  target = PH_BIT_TAIL;
                     PH_BIT_TAIL: begin
                        if (bit_index_ff == '0) begin
                           target = PH_ACK_SETUP;
                        end else begin
                           bit_index_in = bit_index_ff - 3'd1;
                           target       = PH_BIT_LOW;
                        end
                     end
                     PH_ACK_SETUP: target = PH_ACK_HIGH1;
                     PH_ACK_HIGH1: begin
                        ack_hold_in = req_bus.payload.sda_in;
                        target      = PH_ACK_HIGH2;
                     end
                     PH_ACK_HIGH2: target = PH_ACK_TAIL;
                     PH_ACK_TAIL: begin
                        if (want_stop_ff) begin
                           target = PH_STOP_LOW;
                        end else begin
                           target = PH_IDLE;
                           done   = 1'b1;
                        end
                     end
                     PH_STOP_LOW:  target = PH_STOP_HIGH;
                     PH_STOP_HIGH: begin
                        sda_drive_in = 1'b0;
                        target       = PH_IDLE;
                        done         = 1'b1;
                     end
                     default:      target = PH_IDLE;
                  endcase
               end
            end
         end
      end

      // enter the new phase: set its line levels and unit count
      if (do_enter) begin
         phase_in      = target;
         tick_count_in = '0;
         case (target)
            PH_START: begin
               sda_drive_in = 1'b1;
               units_in     = 2'd2;
            end
            PH_BIT_LOW: begin
               scl_drive_in = 1'b1;
               sda_drive_in = !shift_in[bit_index_in];
               units_in     = 2'd1;
            end
            PH_BIT_HIGH: begin
               scl_drive_in = 1'b0;
               units_in     = 2'd2;
            end
            PH_BIT_TAIL, PH_ACK_TAIL: begin
               scl_drive_in = 1'b1;
               units_in     = 2'd1;
            end
            PH_ACK_SETUP: begin
               sda_drive_in = 1'b0;
               units_in     = 2'd1;
            end
            PH_ACK_HIGH1, PH_STOP_HIGH: begin
               scl_drive_in = 1'b0;
               units_in     = 2'd1;
            end
            PH_ACK_HIGH2: units_in = 2'd1;
            PH_STOP_LOW: begin
               sda_drive_in = 1'b1;
               units_in     = 2'd2;
            end
            default: begin
               phase_in = PH_IDLE;
               units_in = 2'd0;
            end
         endcase
      end

      rsp_in.scl_low   = scl_drive_in;
      rsp_in.sda_low   = sda_drive_in;
      rsp_in.busy_res  = (phase_in != PH_IDLE);
      rsp_in.byte_done = done;
      rsp_in.ack_level = ack_hold_in;
      rsp_in.rejected  = rej;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_index_ff  <= BIT_MSB;
         shift_ff      <= '0;
         tick_count_ff <= '0;
         units_ff      <= '0;
         want_stop_ff  <= 1'b0;
         ack_hold_ff   <= 1'b1;
         scl_drive_ff  <= 1'b0;
         sda_drive_ff  <= 1'b0;
         tpu_ff        <= TPU_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         bit_index_ff  <= bit_index_in;
         shift_ff      <= shift_in;
         tick_count_ff <= tick_count_in;
         units_ff      <= units_in;
         want_stop_ff  <= want_stop_in;
         ack_hold_ff   <= ack_hold_in;
         scl_drive_ff  <= scl_drive_in;
         sda_drive_ff  <= sda_drive_in;
         if (csr_bus.valid) begin
            tpu_ff <= csr_bus.data;
         end
         // hold the result word until it is taken
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.byte_done |-> !rsp_ff.busy_res)
      else $error("byte_done word reports busy");

   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.rejected |-> rsp_ff.busy_res && !rsp_ff.byte_done)
      else $error("rejected word while not busy");

   a_units_live: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_IDLE |-> units_ff != 2'd0)
      else $error("active phase with no units left");

   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> tick_count_ff == '0)
      else $error("tick counter running while idle");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready |-> !req_fire)
      else $error("request taken while result word stalled");

endmodule
